>>> sv/bgc_pkg.sv
// bgc_pkg: shared types and constants for the button gesture classifier.
// No dependencies; every other file of the block refers to it by scoped names.

package bgc_pkg;

    // Gesture phase of the back end
    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_WINDOW       = 3'd1,
        PH_HOLD         = 3'd2,
        PH_LONG_RELEASE = 3'd3,
        PH_READOUT      = 3'd4
    } phase_t;

    // Reported event codes
    typedef enum logic [1:0] {
        G_NONE   = 2'd0,
        G_SINGLE = 2'd1,
        G_DOUBLE = 2'd2,
        G_LONG   = 2'd3
    } gesture_t;

    // Configuration register indexes
    typedef enum logic [7:0] {
        CFG_DEBOUNCE = 8'd0,
        CFG_DOUBLE   = 8'd1,
        CFG_LONG     = 8'd2,
        CFG_READOUT  = 8'd3
    } cfg_index_t;

    localparam int unsigned CFG_WIDTH = 16;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_RESET   = 16'd350;
    localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd3000;
    localparam logic [CFG_WIDTH-1:0] READOUT_RESET  = 16'd5000;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] double_window_ticks;
        logic [CFG_WIDTH-1:0] long_hold_ticks;
        logic [CFG_WIDTH-1:0] readout_ticks;
    } cfg_t;

    // Classified tick passed from the front end to the back end
    typedef struct packed {
        logic press;
        logic release_edge;
    } edge_t;

endpackage

>>> sv/button_gesture_classifier_unit.sv
// button_gesture_classifier_unit: top level of the button gesture classifier.
// Depends on bgc_pkg, bgc_front, bgc_queue and bgc_back.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   s_      | s_tvalid / s_tready | s_tdata[0] button_level, [7:1] zero
//   m_      | m_tvalid / m_tready | m_tdata[1:0] gesture, [2] readout_active,
//           |                     |   [3] gesture_busy, [7:4] zero
//   cfg_    | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// One tick is taken per cycle while the queue is not full. An accepted tick
// is written into the queue, then popped into the result register that
// drives m_; no result bypasses either register.
// The front end debounces raw edges in the accept cycle; the back end runs
// the gesture state machine when it pops the queue into the result register.
// aresetn is synchronous, active low; it resets all timers and phases and
// loads the register reset values. A stall on m_ fills the two-entry queue
// and then drops s_tready; configuration writes are always taken.

module button_gesture_classifier_unit #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
    // gesture results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] gesture, [2] readout_active,
                                   // [3] gesture_busy, [7:4] zero
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    bgc_pkg::cfg_t  cfg_reg;
    logic           q_full, q_not_empty, q_push, q_pop;
    bgc_pkg::edge_t push_edge, pop_edge;
    logic [1:0]     gesture;
    logic           readout_active, gesture_busy;

    // Registers are always writable; an unknown index is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks      <= bgc_pkg::DEBOUNCE_RESET;
            cfg_reg.double_window_ticks <= bgc_pkg::DOUBLE_RESET;
            cfg_reg.long_hold_ticks     <= bgc_pkg::LONG_RESET;
            cfg_reg.readout_ticks       <= bgc_pkg::READOUT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bgc_pkg::CFG_DEBOUNCE: cfg_reg.debounce_ticks      <= cfg_data;
                bgc_pkg::CFG_DOUBLE:   cfg_reg.double_window_ticks <= cfg_data;
                bgc_pkg::CFG_LONG:     cfg_reg.long_hold_ticks     <= cfg_data;
                bgc_pkg::CFG_READOUT:  cfg_reg.readout_ticks       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: classify each tick as press, release or nothing
    bgc_front #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .in_valid       (s_tvalid),
        .in_level       (s_tdata[0]),
        .in_ready       (s_tready),
        .push           (q_push),
        .push_edge      (push_edge),
        .queue_full     (q_full)
    );

    // Queue: lets the front keep accepting while a result waits
    bgc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_edge (push_edge),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_edge  (pop_edge)
    );

    // Back: gesture timing and the result register
    bgc_back #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_not_empty      (q_not_empty),
        .q_edge           (pop_edge),
        .q_pop            (q_pop),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_gesture        (gesture),
        .m_readout_active (readout_active),
        .m_gesture_busy   (gesture_busy)
    );

    assign m_tdata = {4'b0000, gesture_busy, readout_active, gesture};

    // A double ends the gesture: nothing timed, no readout
    a_double_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == bgc_pkg::G_DOUBLE) |-> !m_tdata[2] && !m_tdata[3])
        else $error("double reported with gesture still open");

    // A long press leaves neither timing nor readout active
    a_long_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == bgc_pkg::G_LONG) |-> !m_tdata[2] && !m_tdata[3])
        else $error("long reported with timing or readout active");

    // Readout and timing never overlap
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("readout and gesture timing both active");

endmodule

>>> sv/bgc_front.sv
// bgc_front: raw edge detection and debounce for the button gesture classifier.
// Depends on bgc_pkg (edge_t, CFG_WIDTH).

module bgc_front #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bgc_pkg::CFG_WIDTH-1:0] debounce_ticks,
    input  logic                          in_valid,
    input  logic                          in_level,
    output logic                          in_ready,
    output logic                          push,
    output bgc_pkg::edge_t                push_edge,
    input  logic                          queue_full
);

    localparam int CW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;
    localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = '1;

    logic                         last_level_reg, last_level_next;
    logic [TICK_COUNTER_BITS-1:0] since_edge_reg, since_edge_next;
    logic [TICK_COUNTER_BITS-1:0] elapsed;
    logic                         edge_ok;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb begin
        elapsed   = (since_edge_reg == TICK_MAX) ? since_edge_reg
                                                 : since_edge_reg + 1'b1;
        edge_ok   = (CW'(elapsed) >= CW'(debounce_ticks));
        push_edge = '0;
        last_level_next = in_level;
        if (in_level != last_level_reg) begin
            push_edge.press        = edge_ok && in_level;
            push_edge.release_edge = edge_ok && !in_level;
            since_edge_next        = '0;
        end else begin
            since_edge_next = elapsed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg <= 1'b0;
            since_edge_reg <= TICK_MAX;
        end else if (push) begin
            last_level_reg <= last_level_next;
            since_edge_reg <= since_edge_next;
        end
    end

endmodule

>>> sv/bgc_queue.sv
// bgc_queue: two-entry queue of classified ticks between front and back end.
// Depends on bgc_pkg (edge_t).

module bgc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bgc_pkg::edge_t push_edge,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output bgc_pkg::edge_t pop_edge
);

    bgc_pkg::edge_t entry_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_edge  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_edge;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/bgc_back.sv
// bgc_back: gesture state machine and result register of the classifier.
// Depends on bgc_pkg (phase_t, gesture_t, cfg_t, edge_t).

module bgc_back #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bgc_pkg::cfg_t  cfg,
    input  logic           q_not_empty,
    input  bgc_pkg::edge_t q_edge,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_gesture,
    output logic           m_readout_active,
    output logic           m_gesture_busy
);

    localparam int CW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;
    localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = '1;

    bgc_pkg::phase_t              phase_reg, phase_next;
    logic [TICK_COUNTER_BITS-1:0] since_press_reg, since_press_next;
    logic                         released_reg, released_next;
    logic [bgc_pkg::CFG_WIDTH-1:0] readout_left_reg, readout_left_next;
    bgc_pkg::gesture_t            gesture;
    logic [TICK_COUNTER_BITS-1:0] since_press_inc;
    logic                         window_done, hold_done;

    logic                         m_valid_reg;
    bgc_pkg::gesture_t            gesture_reg;
    logic                         readout_reg, busy_reg;

    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);

    always_comb begin
        phase_next        = phase_reg;
        since_press_next  = since_press_reg;
        released_next     = released_reg;
        readout_left_next = readout_left_reg;
        gesture           = bgc_pkg::G_NONE;
        since_press_inc   = (since_press_reg == TICK_MAX) ? since_press_reg
                                                          : since_press_reg + 1'b1;
        window_done = (CW'(since_press_inc) >= CW'(cfg.double_window_ticks));
        hold_done   = (CW'(since_press_inc) >= CW'(cfg.long_hold_ticks));
        unique case (phase_reg)
            bgc_pkg::PH_WINDOW: begin
                since_press_next = since_press_inc;
                if (window_done) begin
                    if (released_reg) begin
                        gesture           = bgc_pkg::G_SINGLE;
                        phase_next        = bgc_pkg::PH_READOUT;
                        readout_left_next = cfg.readout_ticks;
                    end else if (hold_done) begin
                        gesture    = bgc_pkg::G_LONG;
                        phase_next = bgc_pkg::PH_LONG_RELEASE;
                    end else if (q_edge.release_edge) begin
                        gesture           = bgc_pkg::G_SINGLE;
                        phase_next        = bgc_pkg::PH_READOUT;
                        readout_left_next = cfg.readout_ticks;
                    end else begin
                        phase_next = bgc_pkg::PH_HOLD;
                    end
                end else if (q_edge.press) begin
                    gesture    = bgc_pkg::G_DOUBLE;
                    phase_next = bgc_pkg::PH_IDLE;
                end else if (q_edge.release_edge) begin
                    released_next = 1'b1;
                end
            end
            bgc_pkg::PH_HOLD: begin
                since_press_next = since_press_inc;
                if (hold_done) begin
                    gesture    = bgc_pkg::G_LONG;
                    phase_next = bgc_pkg::PH_LONG_RELEASE;
                end else if (q_edge.release_edge) begin
                    gesture           = bgc_pkg::G_SINGLE;
                    phase_next        = bgc_pkg::PH_READOUT;
                    readout_left_next = cfg.readout_ticks;
                end
            end
            bgc_pkg::PH_LONG_RELEASE: begin
                if (q_edge.release_edge) phase_next = bgc_pkg::PH_IDLE;
            end
            bgc_pkg::PH_READOUT: begin
                if (q_edge.press) begin
                    phase_next        = bgc_pkg::PH_WINDOW;
                    since_press_next  = '0;
                    released_next     = 1'b0;
                    readout_left_next = '0;
                end else begin
                    if (readout_left_reg != '0) begin
                        readout_left_next = readout_left_reg - 1'b1;
                    end
                    if (readout_left_next == '0) phase_next = bgc_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = bgc_pkg::PH_IDLE;
                if (q_edge.press) begin
                    phase_next        = bgc_pkg::PH_WINDOW;
                    since_press_next  = '0;
                    released_next     = 1'b0;
                    readout_left_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= bgc_pkg::PH_IDLE;
            since_press_reg  <= '0;
            released_reg     <= 1'b0;
            readout_left_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg        <= phase_next;
                since_press_reg  <= since_press_next;
                released_reg     <= released_next;
                readout_left_reg <= readout_left_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            gesture_reg <= gesture;
            readout_reg <= (phase_next == bgc_pkg::PH_READOUT);
            busy_reg    <= (phase_next == bgc_pkg::PH_WINDOW)
                        || (phase_next == bgc_pkg::PH_HOLD);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_gesture        = gesture_reg;
    assign m_readout_active = readout_reg;
    assign m_gesture_busy   = busy_reg;

    // A single always opens the readout window
    a_single_opens_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && (gesture == bgc_pkg::G_SINGLE) |=> readout_reg)
        else $error("single press did not open readout");

    // A long press ends timing and waits for the release
    a_long_waits_release: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && (gesture == bgc_pkg::G_LONG) |=> (phase_reg == bgc_pkg::PH_LONG_RELEASE))
        else $error("long press did not move to release wait");

    // The result register only advances when its slot is free or drained
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(gesture_reg))
        else $error("pending result overwritten");

endmodule
